// ----- design/cdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdr_pkg;

  localparam int MAX_REQUEST  = 256;
  localparam int STORE_DEPTH  = 256;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int HEADER_BYTES = 12;
  localparam int MIN_QUERY    = 17;
  localparam int ANSWER_BYTES = 16;
  localparam int TAIL_BYTES   = 5;   // root byte, type, class
  localparam int RAM_DEPTH    = 2 * STORE_DEPTH;
  localparam int RAM_AW       = $clog2(RAM_DEPTH);
  localparam int JOB_DEPTH    = 2;
  localparam int JOB_PTR_W    = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W    = $clog2(JOB_DEPTH + 1);

  localparam int BEAT_BYTES   = 8;
  localparam int BEAT_W       = 8 * BEAT_BYTES;
  localparam int BCNT_W       = 4;
  localparam int OUT_DATA_W   = 72;

  localparam int CFG_IDX_W    = 1;
  localparam int CFG_W        = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TTL     = 1'b1;
  localparam logic [CFG_W-1:0] ADDRESS_RESET = 32'hC0A8_0401;
  localparam logic [CFG_W-1:0] TTL_RESET     = 32'd60;

  // header byte positions
  localparam logic [CNT_W-1:0] HDR_FLAGS_HI = 9'd2;
  localparam logic [CNT_W-1:0] HDR_FLAGS_LO = 9'd3;
  localparam logic [CNT_W-1:0] HDR_QD_HI    = 9'd4;
  localparam logic [CNT_W-1:0] HDR_QD_LO    = 9'd5;
  localparam logic [CNT_W-1:0] HDR_AN_HI    = 9'd6;
  localparam logic [CNT_W-1:0] HDR_AN_LO    = 9'd7;
  localparam logic [CNT_W-1:0] HDR_NS_HI    = 9'd8;
  localparam logic [CNT_W-1:0] HDR_NS_LO    = 9'd9;
  localparam logic [CNT_W-1:0] HDR_AR_HI    = 9'd10;
  localparam logic [CNT_W-1:0] HDR_AR_LO    = 9'd11;

  typedef struct packed {
    logic             bank;
    logic             drop;
    logic [CNT_W-1:0] qlen;
  } job_t;

  // Byte k of the fixed A answer record.
  function automatic logic [7:0] answer_byte(input logic [3:0] k,
                                             input logic [CFG_W-1:0] ttl,
                                             input logic [CFG_W-1:0] addr);
    logic [7:0] b;
    case (k)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'h0C;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      default: b = addr[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- design/cdr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/cdr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdr_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_valid_i,
  output logic                            s_ready_o,
  input  wire logic [7:0]                 query_byte_i,
  input  wire logic                       query_last_i,
  output logic                            ram_we_o,
  output logic [cdr_pkg::RAM_AW-1:0]      ram_waddr_o,
  output logic [7:0]                      ram_wdata_o,
  output logic                            job_push_o,
  output cdr_pkg::job_t                   job_o,
  input  wire logic                       job_full_i
);
  import cdr_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] next_q, next_d;
  logic             closed_q, closed_d;
  logic             overrun_q, overrun_d;
  logic             qd_hi_ok_q, qd_hi_ok_d;
  logic             qd_lo_ok_q, qd_lo_ok_d;
  logic             bank_q, bank_d;
  logic             accept;
  logic [CNT_W:0]   qlen;
  logic             drop;

  // bank of the oldest queued job equals bank_q only when the queue is full
  assign s_ready_o   = !job_full_i;
  assign accept      = s_valid_i && s_ready_o;
  assign ram_wdata_o = query_byte_i;
  assign ram_waddr_o = {bank_q, cnt_q[IDX_W-1:0]};

  always_comb begin
    cnt_d      = cnt_q;
    next_d     = next_q;
    closed_d   = closed_q;
    overrun_d  = overrun_q;
    qd_hi_ok_d = qd_hi_ok_q;
    qd_lo_ok_d = qd_lo_ok_q;
    bank_d     = bank_q;
    ram_we_o   = 1'b0;
    job_push_o = 1'b0;

    if (accept && cnt_q < CNT_W'(MAX_REQUEST)) begin
      ram_we_o = 1'b1;
      cnt_d    = cnt_q + CNT_W'(1);
      if (cnt_q == HDR_QD_HI) begin
        qd_hi_ok_d = (query_byte_i == 8'h00);
      end
      if (cnt_q == HDR_QD_LO) begin
        qd_lo_ok_d = (query_byte_i == 8'h01);
      end
      if (!closed_q && !overrun_q && cnt_q == next_q) begin
        if (query_byte_i == 8'h00) begin
          closed_d = 1'b1;
        end else begin
          next_d = cnt_q + CNT_W'(query_byte_i) + CNT_W'(1);
          if (next_d >= CNT_W'(MAX_REQUEST)) begin
            overrun_d = 1'b1;
          end
        end
      end
    end

    qlen = {1'b0, next_d} + (CNT_W+1)'(TAIL_BYTES);
    drop = (cnt_d < CNT_W'(MIN_QUERY)) || !qd_hi_ok_d || !qd_lo_ok_d || !closed_d ||
           (qlen > {1'b0, cnt_d}) || (qlen > (CNT_W+1)'(STORE_DEPTH));
    job_o.bank = bank_q;
    job_o.drop = drop;
    job_o.qlen = qlen[CNT_W-1:0];

    if (accept && query_last_i) begin
      job_push_o = 1'b1;
      bank_d     = !bank_q;
      cnt_d      = '0;
      next_d     = CNT_W'(HEADER_BYTES);
      closed_d   = 1'b0;
      overrun_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      next_q     <= CNT_W'(HEADER_BYTES);
      closed_q   <= 1'b0;
      overrun_q  <= 1'b0;
      qd_hi_ok_q <= 1'b0;
      qd_lo_ok_q <= 1'b0;
      bank_q     <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      next_q     <= next_d;
      closed_q   <= closed_d;
      overrun_q  <= overrun_d;
      qd_hi_ok_q <= qd_hi_ok_d;
      qd_lo_ok_q <= qd_lo_ok_d;
      bank_q     <= bank_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/cdr_job_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdr_job_fifo (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  cdr_pkg::job_t job_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output cdr_pkg::job_t job_o,
  output logic        empty_o
);
  import cdr_pkg::*;

  job_t                 slot_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_q, rd_q;
  logic [JOB_CNT_W-1:0] count_q;

  assign full_o  = (count_q == JOB_CNT_W'(JOB_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_q + JOB_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_q + JOB_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + JOB_CNT_W'(1);
        2'b01:   count_q <= count_q - JOB_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/cdr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdr_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  cdr_pkg::job_t                   job_i,
  input  wire logic                       job_empty_i,
  output logic                            job_pop_o,
  output logic [cdr_pkg::RAM_AW-1:0]      ram_raddr_o,
  input  wire logic [7:0]                 ram_rdata_i,
  input  wire logic [cdr_pkg::CFG_W-1:0]  answer_address_i,
  input  wire logic [cdr_pkg::CFG_W-1:0]  answer_ttl_i,
  output logic                            m_valid_o,
  input  wire logic                       m_ready_i,
  output logic [cdr_pkg::BEAT_W-1:0]      reply_beat_o,
  output logic [cdr_pkg::BCNT_W-1:0]      beat_bytes_o,
  output logic                            reply_end_o,
  output logic                            query_dropped_o
);
  import cdr_pkg::*;

  // read issue
  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  // byte stage, aligned with the registered ram read
  logic              v1_q, v1_d;
  logic [CNT_W-1:0]  idx1_q, idx1_d;
  // beat assembly
  logic [BEAT_W-1:0] acc_q, acc_d;
  logic [BCNT_W-1:0] acnt_q, acnt_d;
  logic              done_q, done_d;
  logic              aend_q, aend_d;
  // output register
  logic              mv_q, mv_d;
  logic [BEAT_W-1:0] obeat_q, obeat_d;
  logic [BCNT_W-1:0] obytes_q, obytes_d;
  logic              oend_q, oend_d;
  logic              odrop_q, odrop_d;

  logic [CNT_W-1:0]  total;
  logic              head_valid, issue_ok, consume, adv, last1, out_free;
  logic [7:0]        byte1;
  logic [2:0]        lane;

  assign head_valid = !job_empty_i;
  assign total      = job_i.qlen + CNT_W'(ANSWER_BYTES);
  assign issue_ok   = head_valid && !job_i.drop && (rd_ptr_q < total);
  assign consume    = v1_q && !done_q;
  assign adv        = !v1_q || consume;
  assign last1      = (idx1_q == total - CNT_W'(1));
  assign out_free   = !mv_q || m_ready_i;
  assign lane       = ~acnt_q[2:0];

  // hold the address while the byte stage is stalled so the read data stays put
  assign ram_raddr_o = {job_i.bank, adv ? rd_ptr_q[IDX_W-1:0] : idx1_q[IDX_W-1:0]};

  always_comb begin
    if (idx1_q < job_i.qlen) begin
      case (idx1_q)
        HDR_FLAGS_HI: byte1 = {7'h40, ram_rdata_i[0]};
        HDR_FLAGS_LO: byte1 = 8'h80;
        HDR_AN_LO:    byte1 = 8'h01;
        HDR_AN_HI, HDR_NS_HI, HDR_NS_LO, HDR_AR_HI, HDR_AR_LO: byte1 = 8'h00;
        default:      byte1 = ram_rdata_i;
      endcase
    end else begin
      byte1 = answer_byte(4'(idx1_q - job_i.qlen), answer_ttl_i, answer_address_i);
    end
  end

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    v1_d      = v1_q;
    idx1_d    = idx1_q;
    acc_d     = acc_q;
    acnt_d    = acnt_q;
    done_d    = done_q;
    aend_d    = aend_q;
    mv_d      = mv_q;
    obeat_d   = obeat_q;
    obytes_d  = obytes_q;
    oend_d    = oend_q;
    odrop_d   = odrop_q;
    job_pop_o = 1'b0;

    if (adv) begin
      v1_d   = issue_ok;
      idx1_d = rd_ptr_q;
      if (issue_ok) begin
        rd_ptr_d = rd_ptr_q + CNT_W'(1);
      end
    end

    if (consume) begin
      acc_d[{lane, 3'b000} +: 8] = byte1;
      acnt_d = acnt_q + BCNT_W'(1);
      if (acnt_q == BCNT_W'(BEAT_BYTES - 1) || last1) begin
        done_d = 1'b1;
        aend_d = last1;
      end
      if (last1) begin
        job_pop_o = 1'b1;
        rd_ptr_d  = '0;
      end
    end

    if (done_q && out_free) begin
      mv_d     = 1'b1;
      obeat_d  = acc_q;
      obytes_d = acnt_q;
      oend_d   = aend_q;
      odrop_d  = 1'b0;
      acc_d    = '0;
      acnt_d   = '0;
      done_d   = 1'b0;
      aend_d   = 1'b0;
    end else if (head_valid && job_i.drop && out_free && !v1_q) begin
      mv_d      = 1'b1;
      obeat_d   = '0;
      obytes_d  = '0;
      oend_d    = 1'b1;
      odrop_d   = 1'b1;
      job_pop_o = 1'b1;
    end else if (m_ready_i) begin
      mv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      v1_q     <= 1'b0;
      idx1_q   <= '0;
      acc_q    <= '0;
      acnt_q   <= '0;
      done_q   <= 1'b0;
      aend_q   <= 1'b0;
      mv_q     <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      v1_q     <= v1_d;
      idx1_q   <= idx1_d;
      acc_q    <= acc_d;
      acnt_q   <= acnt_d;
      done_q   <= done_d;
      aend_q   <= aend_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obeat_q  <= obeat_d;
    obytes_q <= obytes_d;
    oend_q   <= oend_d;
    odrop_q  <= odrop_d;
  end

  assign m_valid_o       = mv_q;
  assign reply_beat_o    = obeat_q;
  assign beat_bytes_o    = obytes_q;
  assign reply_end_o     = oend_q;
  assign query_dropped_o = odrop_q;

endmodule

`default_nettype wire

// ----- design/captive_dns_responder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-----------------------------------------------
// s_axis    | in  | tvalid / tready        | tdata[7:0] query_byte, tlast query_last
// m_axis    | out | tvalid / tready        | tdata reply_beat/beat_bytes, tlast, tuser drop
// cfg       | in  | cfg_we_i, no back-pres.| cfg_index_i register, cfg_data_i value
//
// Query bytes are taken one per cycle, while the job queue has room, into one bank
// of a two-bank byte RAM. A reply is read back one byte a cycle within a beat
// through the RAM read port; each finished beat then moves to the output register.
// A drop word is sent once its job reaches the head of the job queue.
// Up to two finished queries wait in the job queue; the input stalls only when
// both banks are taken. Reset clears control state; the RAM is not cleared.

module captive_dns_responder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,   // [7:0] query_byte
  input  wire logic                          s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [cdr_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,   // [63:0] reply_beat,
                                                               // [67:64] beat_bytes
  output logic                               m_axis_tlast_o,
  output logic                               m_axis_tuser_o,   // [0] query_dropped
  input  wire logic                          cfg_we_i,
  input  wire logic [cdr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [cdr_pkg::CFG_W-1:0]     cfg_data_i
);
  import cdr_pkg::*;

  logic [CFG_W-1:0]  address_q, ttl_q;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              job_push, job_pop, job_full, job_empty;
  job_t              job_in, job_head;
  logic [BEAT_W-1:0] reply_beat;
  logic [BCNT_W-1:0] beat_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= ADDRESS_RESET;
      ttl_q     <= TTL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ANSWER_ADDRESS: address_q <= cfg_data_i;
        REG_ANSWER_TTL:     ttl_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cdr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .query_byte_i (s_axis_tdata_i),
    .query_last_i (s_axis_tlast_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .job_push_o   (job_push),
    .job_o        (job_in),
    .job_full_i   (job_full)
  );

  cdr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cdr_job_fifo u_jobs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (job_head),
    .empty_o (job_empty)
  );

  cdr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job_head),
    .job_empty_i      (job_empty),
    .job_pop_o        (job_pop),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .answer_address_i (address_q),
    .answer_ttl_i     (ttl_q),
    .m_valid_o        (m_axis_tvalid_o),
    .m_ready_i        (m_axis_tready_i),
    .reply_beat_o     (reply_beat),
    .beat_bytes_o     (beat_bytes),
    .reply_end_o      (m_axis_tlast_o),
    .query_dropped_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {(OUT_DATA_W - BEAT_W - BCNT_W)'(0), beat_bytes, reply_beat};

endmodule

`default_nettype wire

// ----- design/cdr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdr_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic                          s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,
  input  wire logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic [cdr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  wire logic                          m_axis_tlast_o,
  input  wire logic                          m_axis_tuser_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cdr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [cdr_pkg::CFG_W-1:0]     cfg_data_i
);

  // a drop word is a lone, empty, final word
  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == '0)
    else $error("drop word not empty or not last");

  // reply words carry one to eight bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[67:64] != 4'd0 && m_axis_tdata_o[67:64] <= 4'd8)
    else $error("reply word byte count out of range");

  // only the final word of a reply may be short
  a_full_middle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[67:64] == 4'd8)
    else $error("short word before end of reply");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

endmodule

bind captive_dns_responder_unit cdr_checker u_cdr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i),
  .cfg_data_i      (cfg_data_i)
);

`default_nettype wire

// ----- test/tb_captive_dns_responder_unit.sv -----
`timescale 1ns / 1ps

module tb_captive_dns_responder_unit;
  import cdr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 500;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_DIRECTED   = 17;

  localparam logic [7:0]  REPLY_FLAGS_HI = 8'h80;  // QR
  localparam logic [7:0]  REPLY_FLAGS_LO = 8'h80;  // RA
  localparam logic [7:0]  RD_MASK        = 8'h01;
  localparam logic [15:0] NAME_PTR       = 16'hC00C;
  localparam logic [15:0] RR_TYPE_A      = 16'h0001;
  localparam logic [15:0] RR_CLASS_IN    = 16'h0001;
  localparam logic [15:0] RDLENGTH_A     = 16'h0004;

  typedef struct packed {
    logic [BEAT_W-1:0] beat;
    logic [BCNT_W-1:0] nbytes;
    logic              last;
    logic              drop;
  } reply_word_t;

  localparam reply_word_t DROP_WORD = '{beat: '0, nbytes: '0, last: 1'b1, drop: 1'b1};

  typedef struct {
    bit          noise;      // all bytes random, keep gives the length
    logic [7:0]  flags_hi;
    logic [15:0] qdcount;
    int          n_labels;
    int          label_len;  // 0: random 1..8 per label
    int          tail;       // bytes after the root label
    int          extra;      // further bytes after tail
    int          keep;       // cut the query to this many bytes, 0 keeps all
    bit          want_drop;
  } query_case_t;

  // noise flags qdcount nlab llen tail extra keep drop
  query_case_t directed_cases [NUM_DIRECTED] = '{
    '{0, 8'h00, 16'h0001, 0, 0,   4, 0,  0,  0},  // bare root name, reset registers
    '{0, 8'hFF, 16'h0001, 1, 3,   4, 0,  0,  0},  // every flag bit set, RD kept
    '{0, 8'h01, 16'h0001, 6, 1,   4, 0,  0,  0},  // many one-byte labels
    '{0, 8'h00, 16'h0001, 2, 7,   4, 9,  0,  0},  // bytes after the question
    '{0, 8'h00, 16'h0001, 0, 0,   4, 0,  1,  1},  // single byte
    '{0, 8'h00, 16'h0001, 0, 0,   4, 0,  16, 1},  // one byte short of minimum
    '{0, 8'h00, 16'h0000, 1, 4,   4, 0,  0,  1},  // no question
    '{0, 8'h00, 16'h0002, 1, 4,   4, 0,  0,  1},
    '{0, 8'h00, 16'h0101, 1, 4,   4, 0,  0,  1},
    '{0, 8'hFF, 16'hFFFF, 1, 4,   4, 0,  0,  1},
    '{0, 8'h00, 16'h0001, 1, 5,   3, 0,  0,  1},  // class cut short
    '{0, 8'h00, 16'h0001, 2, 5,   0, 0,  0,  1},  // ends on the root byte
    '{0, 8'h00, 16'h0001, 1, 10,  4, 0,  20, 1},  // label runs past the last byte
    '{0, 8'h00, 16'h0001, 1, 255, 4, 0,  30, 1},  // label points past the store
    '{0, 8'h00, 16'h0001, 1, 238, 4, 44, 0,  0},  // full store, overlong query
    '{0, 8'h00, 16'h0001, 1, 239, 4, 10, 0,  1},  // root one byte too late
    '{1, 8'h00, 16'h0000, 0, 0,   0, 0,  5,  1}   // short noise
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  wire                    s_axis_tready_o;
  logic [7:0]             s_axis_tdata_i;
  logic                   s_axis_tlast_i;
  wire                    m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  wire [OUT_DATA_W-1:0]   m_axis_tdata_o;
  wire                    m_axis_tlast_o;
  wire                    m_axis_tuser_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;

  captive_dns_responder_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // responder state as the predictor sees it
  logic [7:0]  q_bytes [STORE_DEPTH];
  int          q_count;
  int          label_at;
  bit          q_closed;
  bit          q_overrun;
  logic [31:0] reply_address;
  logic [31:0] reply_ttl;

  reply_word_t new_words [$];
  reply_word_t expected_replies [$];
  logic [7:0]  query_bytes [$];

  int  err_count;
  int  idle_cycles;
  bit  gaps_on;
  bit  hold_req;
  reply_word_t seen_word;
  reply_word_t want_word;

  wire in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  wire out_fire = m_axis_tvalid_o && m_axis_tready_i;

  function automatic void restart_query();
    q_count   = 0;
    label_at  = HEADER_BYTES;
    q_closed  = 1'b0;
    q_overrun = 1'b0;
  endfunction

  // Feeds one accepted query byte; on the last one, leaves the reply words in new_words.
  function automatic void absorb_query_byte(input logic [7:0] b, input bit last);
    logic [7:0]                  msg [$];
    logic [8*ANSWER_BYTES-1:0]   answer;
    reply_word_t                 w;
    int                          qlen, total, k, i, cnt;
    if (q_count < MAX_REQUEST && q_count < STORE_DEPTH) begin
      q_bytes[q_count] = b;
      if (!q_closed && !q_overrun && q_count == label_at) begin
        if (b == 8'h00) begin
          q_closed = 1'b1;
        end else begin
          label_at = q_count + int'(b) + 1;
          if (label_at >= MAX_REQUEST) q_overrun = 1'b1;
        end
      end
      q_count++;
    end
    if (!last) return;
    new_words.delete();
    qlen = label_at + TAIL_BYTES;
    if (q_count < MIN_QUERY || q_bytes[HDR_QD_HI] != 8'h00 || q_bytes[HDR_QD_LO] != 8'h01 ||
        !q_closed || qlen > q_count || qlen > STORE_DEPTH) begin
      new_words.push_back(DROP_WORD);
      restart_query();
      return;
    end
    for (i = 0; i < qlen; i++) msg.push_back(q_bytes[i]);
    msg[HDR_FLAGS_HI] = REPLY_FLAGS_HI | (q_bytes[HDR_FLAGS_HI] & RD_MASK);
    msg[HDR_FLAGS_LO] = REPLY_FLAGS_LO;
    msg[HDR_AN_HI]    = 8'h00;
    msg[HDR_AN_LO]    = 8'h01;
    msg[HDR_NS_HI]    = 8'h00;
    msg[HDR_NS_LO]    = 8'h00;
    msg[HDR_AR_HI]    = 8'h00;
    msg[HDR_AR_LO]    = 8'h00;
    answer = {NAME_PTR, RR_TYPE_A, RR_CLASS_IN, reply_ttl, RDLENGTH_A, reply_address};
    for (i = 0; i < ANSWER_BYTES; i++) msg.push_back(answer[8*ANSWER_BYTES-1-8*i -: 8]);
    total = msg.size();
    for (k = 0; k < total; k += BEAT_BYTES) begin
      w   = '0;
      cnt = (total - k > BEAT_BYTES) ? BEAT_BYTES : total - k;
      for (i = 0; i < cnt; i++) w.beat[BEAT_W-1-8*i -: 8] = msg[k+i];
      w.nbytes = cnt[BCNT_W-1:0];
      w.last   = (k + BEAT_BYTES >= total);
      new_words.push_back(w);
    end
    restart_query();
  endfunction

  function automatic void build_query(input query_case_t qc);
    int i, j, len;
    query_bytes.delete();
    if (qc.noise) begin
      for (i = 0; i < qc.keep; i++) query_bytes.push_back($urandom_range(0, 255));
      return;
    end
    query_bytes.push_back($urandom_range(0, 255));  // ID
    query_bytes.push_back($urandom_range(0, 255));
    query_bytes.push_back(qc.flags_hi);
    query_bytes.push_back($urandom_range(0, 255));
    query_bytes.push_back(qc.qdcount[15:8]);
    query_bytes.push_back(qc.qdcount[7:0]);
    for (i = 0; i < 6; i++) query_bytes.push_back($urandom_range(0, 255));
    for (i = 0; i < qc.n_labels; i++) begin
      len = (qc.label_len != 0) ? qc.label_len : $urandom_range(1, 8);
      query_bytes.push_back(len[7:0]);
      for (j = 0; j < len; j++) query_bytes.push_back($urandom_range(0, 255));
    end
    query_bytes.push_back(8'h00);
    for (i = 0; i < qc.tail + qc.extra; i++) query_bytes.push_back($urandom_range(0, 255));
    if (qc.keep != 0)
      while (query_bytes.size() > qc.keep) void'(query_bytes.pop_back());
  endfunction

  function automatic query_case_t random_case();
    query_case_t qc;
    qc.noise     = 1'b0;
    qc.flags_hi  = $urandom_range(0, 255);
    qc.qdcount   = 16'h0001;
    qc.n_labels  = $urandom_range(0, 4);
    qc.label_len = 0;
    qc.tail      = 4;
    qc.extra     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    qc.keep      = 0;
    qc.want_drop = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      qc.n_labels  = 1;
      qc.label_len = $urandom_range(60, 200);
    end
    // mostly well-formed; the rest broken in one way
    case ($urandom_range(0, 9))
      0:       qc.qdcount = $urandom_range(0, 65535);
      1:       qc.tail    = $urandom_range(0, 3);
      2:       qc.keep    = $urandom_range(1, 40);
      3: begin
        qc.noise = 1'b1;
        qc.keep  = $urandom_range(1, 24);
      end
      default: ;
    endcase
    return qc;
  endfunction

  function automatic void note_error(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endfunction

  task automatic put_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_query_byte(b, last);
  endtask

  task automatic send_query(input bit typed_drop);
    int i;
    for (i = 0; i < query_bytes.size(); i++)
      put_byte(query_bytes[i], i == query_bytes.size() - 1);
    if (typed_drop) begin
      expected_replies.push_back(DROP_WORD);
    end else begin
      foreach (new_words[i]) expected_replies.push_back(new_words[i]);
    end
  endtask

  task automatic send_random(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_query(random_case());
      send_query(1'b0);
      sent += query_bytes.size();
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ANSWER_ADDRESS: reply_address = val;
      REG_ANSWER_TTL:     reply_ttl     = val;
      default:            ;
    endcase
  endtask

  // reply side: random ready gaps, plus one long hold-off on request
  initial begin
    int gap;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_fire) begin
      seen_word.beat   = m_axis_tdata_o[BEAT_W-1:0];
      seen_word.nbytes = m_axis_tdata_o[BEAT_W +: BCNT_W];
      seen_word.last   = m_axis_tlast_o;
      seen_word.drop   = m_axis_tuser_o;
      if (expected_replies.size() == 0) begin
        note_error($sformatf("unexpected word: beat %h bytes %0d end %b drop %b",
                             seen_word.beat, seen_word.nbytes, seen_word.last, seen_word.drop));
      end else begin
        want_word = expected_replies.pop_front();
        if (seen_word.beat !== want_word.beat || seen_word.nbytes !== want_word.nbytes ||
            seen_word.last !== want_word.last || seen_word.drop !== want_word.drop)
          note_error($sformatf({"expected beat %h bytes %0d end %b drop %b, ",
                                "got beat %h bytes %0d end %b drop %b"},
                               want_word.beat, want_word.nbytes, want_word.last,
                               want_word.drop, seen_word.beat, seen_word.nbytes,
                               seen_word.last, seen_word.drop));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_ANSWER_ADDRESS;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    err_count       = 0;
    idle_cycles     = 0;
    gaps_on         = 1'b1;
    hold_req        = 1'b0;
    reply_address   = ADDRESS_RESET;
    reply_ttl       = TTL_RESET;
    restart_query();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_cases[r]) begin
      build_query(directed_cases[r]);
      send_query(directed_cases[r].want_drop);
    end
    drain();

    // back-to-back stretch, zero registers
    gaps_on = 1'b0;
    write_reg(REG_ANSWER_ADDRESS, '0);
    write_reg(REG_ANSWER_TTL, '0);
    send_random(70);
    drain();

    // all-ones registers; reply side stalls long enough to back up both banks
    gaps_on = 1'b1;
    write_reg(REG_ANSWER_ADDRESS, '1);
    write_reg(REG_ANSWER_TTL, '1);
    hold_req = 1'b1;
    send_random(70);
    drain();

    write_reg(REG_ANSWER_ADDRESS, $urandom);
    write_reg(REG_ANSWER_TTL, $urandom_range(0, 300));
    send_random(140);
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
